FILE: hdl/hwa_pkg.sv
// Shared definitions for the histogram window alert unit.
// Holds field widths, command and register codes, reset values and the
// controller-to-datapath command and status types. No dependencies.
package hwa_pkg;

	// Default sizes of the bin store and of the radius cap.
	localparam int NUM_BINS_DEF   = 4096;
	localparam int MAX_RADIUS_DEF = 64;

	// Field and register widths.
	localparam int CMD_W      = 2;
	localparam int POS_W      = 12;
	localparam int RADIUS_W   = 7;
	localparam int THRESH_W   = 24;
	localparam int SUM_W      = 24;
	localparam int BIN_W      = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	// A window holds at most 2 * 127 + 1 = 255 full bins, which fits in 24 bits,
	// so the running sum never needs to saturate.
	localparam int ACC_W = BIN_W + RADIUS_W + 1;

	// Bin counter ceiling.
	localparam logic [BIN_W-1:0] BIN_MAX = '1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

	// Configuration reset values.
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 7'd8;
	localparam logic [THRESH_W-1:0] THRESH_RST = 24'd100;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the request and set up the pointer
		logic clr_start;  // with capture: start the pointer at the first bin
		logic clr_wr;     // write zero at the pointer and advance it
		logic add_rd;     // read the bin addressed by the latched position
		logic add_wr;     // write back the incremented bin
		logic q_rd;       // read the bin at the pointer and advance it
		logic q_load;     // load the result register
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;  // the pointer is at the last bin
		logic q_last;    // the pointer is at the top of the window
		logic q_empty;   // the window for the offered request is empty
		logic out_free;  // the result register can take a new result
	} dp_stat_t;

endpackage

FILE: hdl/hwa_ctrl.sv
// Controller state machine for the histogram window alert unit.
// Sequences clear sweeps, read-modify-write adds and window queries.
// Depends on hwa_pkg.
module hwa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [hwa_pkg::CMD_W-1:0] cmd,
	input  hwa_pkg::dp_stat_t      stat,
	output hwa_pkg::dp_ctrl_t      ctrl
);
	import hwa_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLEAR  = 7'b0000010,
		ST_ADD_RD = 7'b0000100,
		ST_ADD_WR = 7'b0001000,
		ST_Q_RD   = 7'b0010000,
		ST_Q_WAIT = 7'b0100000,
		ST_Q_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A request is taken only when the controller is idle.
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.capture = 1'b1;
					if (cmd == CMD_ADD) begin
						state_d = ST_ADD_RD;
					end else if (cmd == CMD_QUERY) begin
						state_d = stat.q_empty ? ST_Q_DONE : ST_Q_RD;
					end else if (cmd == CMD_CLEAR) begin
						ctrl.clr_start = 1'b1;
						state_d        = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD_RD: begin
				ctrl.add_rd = 1'b1;
				state_d     = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				ctrl.add_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_Q_RD: begin
				ctrl.q_rd = 1'b1;
				if (stat.q_last) begin
					state_d = ST_Q_WAIT;
				end
			end
			ST_Q_WAIT: begin
				// The last bin read is added during this cycle.
				state_d = ST_Q_DONE;
			end
			ST_Q_DONE: begin
				if (stat.out_free) begin
					ctrl.q_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts with a clearing pass over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/hwa_datapath.sv
// Datapath for the histogram window alert unit: bin memory, pointer,
// window bounds, accumulator, configuration registers and result register.
// Depends on hwa_pkg.
module hwa_datapath #(
	parameter int NUM_BINS   = hwa_pkg::NUM_BINS_DEF,
	parameter int MAX_RADIUS = hwa_pkg::MAX_RADIUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hwa_pkg::dp_ctrl_t            ctrl,
	output hwa_pkg::dp_stat_t            stat,
	input  logic [hwa_pkg::POS_W-1:0]    position,
	input  logic                         cfg_we,
	input  logic [hwa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hwa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [hwa_pkg::POS_W-1:0]    centre,
	output logic [hwa_pkg::SUM_W-1:0]    window_sum,
	output logic                         alert
);
	import hwa_pkg::*;

	localparam int AW    = $clog2(NUM_BINS);
	localparam int CAP_W = $clog2(MAX_RADIUS + 1);
	localparam int M1    = (POS_W > AW) ? POS_W : AW;
	localparam int M2    = (M1 > CAP_W) ? M1 : CAP_W;
	localparam int IW    = ((M2 > RADIUS_W) ? M2 : RADIUS_W) + 1;

	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);
	localparam logic [IW-1:0] LAST_W    = IW'(NUM_BINS - 1);
	localparam logic [IW-1:0] RCAP_W    = IW'(MAX_RADIUS);

	// Bin store.
	logic [BIN_W-1:0] bin_mem_q [NUM_BINS];
	logic [BIN_W-1:0] rd_data_q;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;
	logic [BIN_W-1:0] wr_data;
	logic             mem_re;
	logic [AW-1:0]    rd_addr;

	// Configuration.
	logic [RADIUS_W-1:0] radius_q;
	logic [THRESH_W-1:0] threshold_q;

	// Request and window state.
	logic [POS_W-1:0] pos_q;
	logic [AW-1:0]    addr_q;
	logic             pos_ok_q;
	logic [AW-1:0]    hi_q;
	logic [AW-1:0]    ptr_q;
	logic             acc_en_s1;
	logic [ACC_W-1:0] acc_q;

	// Window bounds for the offered position.
	logic [IW-1:0] pos_w;
	logic [IW-1:0] rad_w;
	logic [IW-1:0] r_eff;
	logic [IW-1:0] lo_w;
	logic [IW-1:0] hi_sum;
	logic [IW-1:0] hi_w;

	// Result register.
	logic             res_valid_q;
	logic [POS_W-1:0] centre_q;
	logic [SUM_W-1:0] sum_q;
	logic             alert_q;
	logic             out_free;

	// The radius is capped, and the window is clipped to the existing bins.
	always_comb begin
		pos_w  = IW'(position);
		rad_w  = IW'(radius_q);
		r_eff  = (rad_w > RCAP_W) ? RCAP_W : rad_w;
		lo_w   = (pos_w > r_eff) ? (pos_w - r_eff) : '0;
		hi_sum = pos_w + r_eff;
		hi_w   = (hi_sum > LAST_W) ? LAST_W : hi_sum;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			threshold_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS:    radius_q    <= cfg_data[RADIUS_W-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_data[THRESH_W-1:0];
				default:       ;
			endcase
		end
	end

	// Latched request fields and window top.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			pos_q    <= position;
			addr_q   <= pos_w[AW-1:0];
			pos_ok_q <= (pos_w <= LAST_W);
			hi_q     <= hi_w[AW-1:0];
		end
	end

	// Pointer for the clear sweep and the window scan; a sweep always starts at bin zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctrl.capture) begin
			ptr_q <= ctrl.clr_start ? '0 : lo_w[AW-1:0];
		end else if (ctrl.clr_wr || ctrl.q_rd) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// Memory port selection.
	always_comb begin
		mem_re  = ctrl.add_rd || ctrl.q_rd;
		rd_addr = ctrl.add_rd ? addr_q : ptr_q;
		mem_we  = ctrl.clr_wr || (ctrl.add_wr && pos_ok_q && (rd_data_q != BIN_MAX));
		wr_addr = ctrl.clr_wr ? ptr_q : addr_q;
		wr_data = ctrl.clr_wr ? '0 : (rd_data_q + 1'b1);
	end

	// Bin memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= bin_mem_q[rd_addr];
		end
	end

	// Read data arrives in the cycle after the read is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctrl.q_rd;
		end
	end

	// Window sum.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + ACC_W'(rd_data_q);
		end
	end

	// Result register; it frees up in the cycle its result is taken.
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.q_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.q_load) begin
			centre_q <= pos_q;
			sum_q    <= SUM_W'(acc_q);
			alert_q  <= (acc_q > ACC_W'(threshold_q));
		end
	end

	// Status to the controller.
	always_comb begin
		stat.clr_last = (ptr_q == LAST_ADDR);
		stat.q_last   = (ptr_q == hi_q);
		stat.q_empty  = (lo_w > hi_w);
		stat.out_free = out_free;
	end

	assign res_valid  = res_valid_q;
	assign centre     = centre_q;
	assign window_sum = sum_q;
	assign alert      = alert_q;

endmodule

FILE: hdl/histogram_window_alert_unit.sv
// Top level of the histogram window alert unit.
// Joins the controller and the datapath. Depends on hwa_pkg, hwa_ctrl, hwa_datapath.
//
// Usage:
// A request carries cmd and position and is taken when req_valid is high and
// req_stall is low. An add increments the addressed bin (saturating at 65535),
// a query sums the bins within radius of position, clipped to the store, and
// a clear zeroes every bin. Only a query returns a result, on the res channel
// as centre, window_sum and alert (sum strictly above threshold).
// An add reads the addressed bin and then writes it back; a clear writes zero
// to every bin in turn. A query over a window of n bins (n = 17 at the default
// radius) reads one bin per cycle through the single read port of the bin
// memory. One request is in work at a time.
// The result sits in an output register, so the next request is taken while a
// result still waits. If res_stall holds, a finished query waits in the
// controller until the register frees up, and requests stall meanwhile.
// After reset the unit sweeps the bin memory to zero, during which requests
// stall; the configuration port is always writable, with radius at 8 and
// threshold at 100 after reset.
module histogram_window_alert_unit #(
	parameter int NUM_BINS   = hwa_pkg::NUM_BINS_DEF,
	parameter int MAX_RADIUS = hwa_pkg::MAX_RADIUS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [hwa_pkg::CMD_W-1:0]      cmd,
	input  logic [hwa_pkg::POS_W-1:0]      position,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [hwa_pkg::POS_W-1:0]      centre,
	output logic [hwa_pkg::SUM_W-1:0]      window_sum,
	output logic                           alert,
	input  logic                           cfg_we,
	input  logic [hwa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hwa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hwa_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	// Sequencing.
	hwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// Storage and arithmetic.
	hwa_datapath #(
		.NUM_BINS   (NUM_BINS),
		.MAX_RADIUS (MAX_RADIUS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.position   (position),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.centre     (centre),
		.window_sum (window_sum),
		.alert      (alert)
	);

endmodule
